[hdl/adpc_pkg.sv]
package adpc_pkg;

	localparam int PIX_W       = 8;
	localparam int VAL_W       = 11;
	localparam int STEP_W      = 12;
	localparam int LINE_W      = 10;
	localparam int BIAS_W      = 8;
	localparam int SMIN_W      = 8;
	localparam int SVAL_W      = 8;
	localparam int SSTEP_W     = 9;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 10;

	localparam int MAX_WIDTH_DEF = 512;

	localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_BIAS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_MIN        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_STEP      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_START_DIRECTION = 3'd6;

	localparam logic [LINE_W-1:0]  LINE_WIDTH_RST  = 10'd512;
	localparam logic [BIAS_W-1:0]  CHANGE_BIAS_RST = 8'd0;
	localparam logic [SMIN_W-1:0]  STEP_MIN_RST    = 8'd1;
	localparam logic [SVAL_W-1:0]  START_VALUE_RST = 8'd128;
	localparam logic [SSTEP_W-1:0] START_STEP_RST  = 9'd8;

	localparam logic signed [STEP_W-1:0] STEP_HI = 12'sd2047;
	localparam logic signed [STEP_W-1:0] STEP_LO = -12'sd2048;
	localparam logic [VAL_W-1:0]         VAL_HI  = 11'd2047;

	typedef logic [VAL_W-1:0]         value_t;
	typedef logic signed [STEP_W-1:0] step_t;

	typedef struct packed {
		value_t value;
		step_t  step;
	} line_entry_t;

endpackage

[hdl/adpc_in_if.sv]
interface adpc_in_if import adpc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             dir_bit_in;
	logic             step_bit_in;
	logic             line_start;
	logic             frame_start;

	modport source (output valid, pixel, dir_bit_in, step_bit_in, line_start, frame_start,
		input ready);
	modport sink (input valid, pixel, dir_bit_in, step_bit_in, line_start, frame_start,
		output ready);
endinterface

[hdl/adpc_out_if.sv]
interface adpc_out_if import adpc_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   dir_bit_out;
	logic   step_bit_out;
	value_t recon_value;

	modport source (output valid, dir_bit_out, step_bit_out, recon_value, input ready);
	modport sink (input valid, dir_bit_out, step_bit_out, recon_value, output ready);
endinterface

[hdl/adaptive_delta_pixel_codec.sv]
// an input transfer loads the stage 1 registers, and stage 1 then loads the result register
// throughput: one pixel per cycle; the line store takes one read at input transfer and
// one write as the result register loads, and input stalls only while a result waits
// line store words are tracked by a fill count, so frame start costs no clearing pass
// arst_n clears control state and loads register defaults; left references, direction
// and the frame start values take their reset-time configuration
module adaptive_delta_pixel_codec import adpc_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	adpc_in_if.sink               pixels,
	adpc_out_if.source            results
);

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int FW   = $clog2(MAX_WIDTH + 1);
	localparam int CMPW = ((FW > LINE_W) ? FW : LINE_W) + 1;

	// configuration
	logic               decode_mode_q;
	logic [LINE_W-1:0]  line_width_q;
	logic [BIAS_W-1:0]  change_bias_q;
	logic [SMIN_W-1:0]  step_min_q;
	logic [SVAL_W-1:0]  start_value_q;
	logic [SSTEP_W-1:0] start_step_q;
	logic               start_dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
			line_width_q  <= LINE_WIDTH_RST;
			change_bias_q <= CHANGE_BIAS_RST;
			step_min_q    <= STEP_MIN_RST;
			start_value_q <= START_VALUE_RST;
			start_step_q  <= START_STEP_RST;
			start_dir_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DECODE_MODE:     decode_mode_q <= cfg_data[0];
				CFG_LINE_WIDTH:      line_width_q  <= cfg_data[LINE_W-1:0];
				CFG_CHANGE_BIAS:     change_bias_q <= cfg_data[BIAS_W-1:0];
				CFG_STEP_MIN:        step_min_q    <= cfg_data[SMIN_W-1:0];
				CFG_START_VALUE:     start_value_q <= cfg_data[SVAL_W-1:0];
				CFG_START_STEP:      start_step_q  <= cfg_data[SSTEP_W-1:0];
				CFG_START_DIRECTION: start_dir_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	value_t start_val;
	step_t  start_stp;
	assign start_val = VAL_W'(start_value_q);
	assign start_stp = step_t'($signed(start_step_q));

	// handshake
	logic s1_valid_q;
	logic out_valid_q;
	logic adv;
	logic take;

	assign adv          = s1_valid_q && (!out_valid_q || results.ready);
	assign pixels.ready = !s1_valid_q || adv;
	assign take         = pixels.valid && pixels.ready;

	// column and fill tracking at input transfer
	logic [AW-1:0]   column_q;
	logic [FW-1:0]   fill_q;
	value_t          frame_val_q;
	step_t           frame_step_q;
	logic            restart;
	logic [AW-1:0]   col_n;
	logic [FW-1:0]   fill_base;
	logic [FW-1:0]   col_inc_f;
	logic [CMPW-1:0] line_ext;
	logic [CMPW-1:0] max_ext;
	logic [CMPW-1:0] eff_width;
	logic [CMPW-1:0] col_inc;

	assign restart   = pixels.frame_start || pixels.line_start;
	assign col_n     = restart ? '0 : column_q;
	assign fill_base = pixels.frame_start ? '0 : fill_q;
	assign col_inc_f = FW'(col_n) + FW'(1);
	assign line_ext  = CMPW'(line_width_q);
	assign max_ext   = CMPW'(MAX_WIDTH);
	assign eff_width = (line_width_q == '0 || line_ext > max_ext) ? max_ext : line_ext;
	assign col_inc   = CMPW'(col_n) + CMPW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			fill_q       <= '0;
			frame_val_q  <= VAL_W'(START_VALUE_RST);
			frame_step_q <= step_t'($signed(START_STEP_RST));
		end else if (take) begin
			column_q <= (col_inc >= eff_width) ? '0 : col_inc[AW-1:0];
			fill_q   <= (col_inc_f > fill_base) ? col_inc_f : fill_base;
			if (pixels.frame_start) begin
				frame_val_q  <= start_val;
				frame_step_q <= start_stp;
			end
		end
	end

	// stage 1 registers
	logic [PIX_W-1:0] pixel_s1;
	logic             dir_in_s1;
	logic             step_in_s1;
	logic             ls_s1;
	logic             fs_s1;
	logic [AW-1:0]    col_s1;
	logic             up_vld_s1;
	logic             byp_s1;
	line_entry_t      rd_s1;
	line_entry_t      line_mem [MAX_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pixels.ready) begin
			s1_valid_q <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pixel_s1   <= pixels.pixel;
			dir_in_s1  <= pixels.dir_bit_in;
			step_in_s1 <= pixels.step_bit_in;
			ls_s1      <= pixels.line_start;
			fs_s1      <= pixels.frame_start;
			col_s1     <= col_n;
			up_vld_s1  <= FW'(col_n) < fill_base;
			byp_s1     <= !pixels.frame_start && adv && (col_n == col_s1);
			rd_s1      <= line_mem[col_n];
		end
	end

	// reference selection
	value_t left_val_q;
	step_t  left_step_q;
	logic   dir_q;
	step_t  wr_step_q;
	value_t out_recon_q;

	value_t bv;
	step_t  cv;
	value_t bh;
	step_t  ch;

	always_comb begin
		if (byp_s1) begin
			bv = out_recon_q;
			cv = wr_step_q;
		end else if (up_vld_s1) begin
			bv = rd_s1.value;
			cv = rd_s1.step;
		end else begin
			bv = frame_val_q;
			cv = frame_step_q;
		end
	end

	assign bh = (ls_s1 || fs_s1) ? start_val : left_val_q;
	assign ch = (ls_s1 || fs_s1) ? start_stp : left_step_q;

	// step clamp so that reference plus step stays at or above zero
	logic signed [STEP_W:0]   sum_v;
	logic signed [STEP_W:0]   sum_h;
	step_t                    cv_c;
	step_t                    ch_c;
	logic signed [STEP_W:0]   pv;
	logic signed [STEP_W:0]   ph;
	logic signed [STEP_W+1:0] dv;
	logic signed [STEP_W+1:0] dh;
	logic signed [STEP_W+1:0] av;
	logic signed [STEP_W+1:0] ah;
	logic signed [STEP_W+2:0] av_b;
	logic signed [STEP_W+2:0] ah_b;
	logic signed [STEP_W+1:0] pix_ext;

	assign sum_v   = $signed({2'b00, bv}) + $signed({cv[STEP_W-1], cv});
	assign sum_h   = $signed({2'b00, bh}) + $signed({ch[STEP_W-1], ch});
	assign cv_c    = (sum_v <= 0) ? -$signed({1'b0, bv}) : cv;
	assign ch_c    = (sum_h <= 0) ? -$signed({1'b0, bh}) : ch;
	assign pv      = $signed({2'b00, bv}) + $signed({cv_c[STEP_W-1], cv_c});
	assign ph      = $signed({2'b00, bh}) + $signed({ch_c[STEP_W-1], ch_c});
	assign pix_ext = decode_mode_q ? '0 : $signed({6'b000000, pixel_s1});
	assign dv      = $signed({pv[STEP_W], pv}) - pix_ext;
	assign dh      = $signed({ph[STEP_W], ph}) - pix_ext;
	assign av      = (dv < 0) ? -dv : dv;
	assign ah      = (dh < 0) ? -dh : dh;
	assign av_b    = $signed({av[STEP_W+1], av}) - $signed({7'b0000000, change_bias_q});
	assign ah_b    = $signed({ah[STEP_W+1], ah}) - $signed({7'b0000000, change_bias_q});

	// direction decision
	logic dir_cur;
	logic dir;

	assign dir_cur = fs_s1 ? start_dir_q : dir_q;

	always_comb begin
		if (decode_mode_q) begin
			dir = dir_in_s1;
		end else if (dir_cur) begin
			dir = ($signed({ah[STEP_W+1], ah}) < av_b) ? 1'b0 : 1'b1;
		end else begin
			dir = ($signed({av[STEP_W+1], av}) < ah_b) ? 1'b1 : 1'b0;
		end
	end

	// step adaptation
	step_t                  c_sel;
	logic signed [STEP_W:0] b_sel;
	logic signed [STEP_W+1:0] d_sel;
	logic                   flag;
	step_t                  c_half;
	step_t                  c_neg;
	step_t                  neg_half;
	logic [STEP_W-1:0]      neg_mag;
	logic [STEP_W-1:0]      halve_lim;
	logic signed [STEP_W:0] c_new;
	step_t                  c_out;
	value_t                 b_out;

	assign c_sel = dir ? cv_c : ch_c;
	assign b_sel = dir ? pv : ph;
	assign d_sel = dir ? dv : dh;

	assign flag = decode_mode_q ? step_in_s1 :
		((d_sel < 0 && c_sel > 0) || (d_sel > 0 && c_sel < 0));

	assign c_half    = (c_sel + $signed({{(STEP_W-1){1'b0}}, c_sel[STEP_W-1]})) >>> 1;
	assign c_neg     = -c_sel;
	assign neg_half  = (c_neg + $signed({{(STEP_W-1){1'b0}}, c_neg[STEP_W-1]})) >>> 1;
	assign neg_mag   = c_neg[STEP_W-1] ? STEP_W'(-c_neg) : STEP_W'(c_neg);
	assign halve_lim = STEP_W'({step_min_q, 1'b0});

	always_comb begin
		if (flag) begin
			c_new = $signed({c_sel[STEP_W-1], c_sel}) + $signed({c_half[STEP_W-1], c_half});
		end else if (neg_mag >= halve_lim) begin
			c_new = $signed({neg_half[STEP_W-1], neg_half});
		end else begin
			c_new = $signed({c_neg[STEP_W-1], c_neg});
		end
	end

	assign c_out = (c_new > $signed({1'b0, STEP_HI})) ? STEP_HI :
		(c_new < $signed({1'b1, STEP_LO})) ? STEP_LO : c_new[STEP_W-1:0];
	assign b_out = (b_sel > $signed({2'b00, VAL_HI})) ? VAL_HI : b_sel[VAL_W-1:0];

	// state update and result register
	always_ff @(posedge clk) begin
		if (adv) begin
			line_mem[col_s1] <= '{value: b_out, step: c_out};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_val_q  <= VAL_W'(START_VALUE_RST);
			left_step_q <= step_t'($signed(START_STEP_RST));
			dir_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				left_val_q  <= b_out;
				left_step_q <= c_out;
				dir_q       <= dir;
			end
			out_valid_q <= adv || (out_valid_q && !results.ready);
		end
	end

	logic out_dir_q;
	logic out_flag_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_dir_q   <= dir;
			out_flag_q  <= flag;
			out_recon_q <= b_out;
			wr_step_q   <= c_out;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.dir_bit_out  = out_dir_q;
	assign results.step_bit_out = out_flag_q;
	assign results.recon_value  = out_recon_q;

	a_fill_covers_column: assert property (@(posedge clk) disable iff (!arst_n)
		FW'(column_q) <= fill_q)
		else $error("column beyond line store fill");

	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> s1_valid_q)
		else $error("transfer lost before stage 1");

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("result register not loaded");

endmodule

[tb/sv/tb_adaptive_delta_pixel_codec.sv]
`timescale 1ns / 100ps

module tb_adaptive_delta_pixel_codec;
	import adpc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             dir_bit;
		logic             step_bit;
		logic             line_start;
		logic             frame_start;
	} pixel_item_t;

	typedef struct {
		logic   dir;
		logic   grow;
		value_t value;
	} codec_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	adpc_in_if  pix_if ();
	adpc_out_if res_if ();

	adaptive_delta_pixel_codec u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pix_if),
		.results   (res_if)
	);

	always #5 clk = ~clk;

	// codec model state
	logic               mode_decode;
	logic [LINE_W-1:0]  width_reg;
	logic [BIAS_W-1:0]  bias_reg;
	logic [SMIN_W-1:0]  step_floor;
	logic [SVAL_W-1:0]  init_value;
	logic [SSTEP_W-1:0] init_step;
	logic               init_dir;

	value_t      upper_val [MAX_WIDTH_DEF];
	step_t       upper_stp [MAX_WIDTH_DEF];
	value_t      left_val;
	step_t       left_stp;
	logic        cur_dir;
	int unsigned col_pos;

	codec_result_t pending_results[$];
	int            fault_count;
	int            cycle_count;
	bit            src_burst;
	bit            snk_burst;
	logic [PIX_W-1:0] last_px;

	function automatic int magnitude(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : int'($urandom_range(0, 9));
	endfunction

	function automatic void restart_line();
		left_val = value_t'(init_value);
		left_stp = {{(STEP_W-SSTEP_W){init_step[SSTEP_W-1]}}, init_step};
		col_pos  = 0;
	endfunction

	function automatic void restart_frame();
		for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
			upper_val[i] = value_t'(init_value);
			upper_stp[i] = {{(STEP_W-SSTEP_W){init_step[SSTEP_W-1]}}, init_step};
		end
		cur_dir = init_dir;
		restart_line();
	endfunction

	function automatic codec_result_t predict_pixel(input pixel_item_t it);
		codec_result_t r;
		int            bv, cv, bh, ch, dv, dh, b, c, d, px, w;
		int unsigned   col;
		logic          dir, grow;
		if (it.frame_start)
			restart_frame();
		else if (it.line_start)
			restart_line();
		col = col_pos % MAX_WIDTH_DEF;
		bv  = int'(upper_val[col]);
		cv  = int'(upper_stp[col]);
		bh  = int'(left_val);
		ch  = int'(left_stp);
		// keep reference plus step from going below zero
		if (cv + bv <= 0)
			cv = -bv;
		if (ch + bh <= 0)
			ch = -bh;
		px = mode_decode ? 0 : int'(it.pixel);
		dh = bh + ch - px;
		dv = bv + cv - px;
		if (mode_decode) begin
			dir = it.dir_bit;
		end else begin
			dir = cur_dir;
			if (dir) begin
				if (magnitude(dh) < magnitude(dv) - int'(bias_reg))
					dir = 1'b0;
			end else begin
				if (magnitude(dv) < magnitude(dh) - int'(bias_reg))
					dir = 1'b1;
			end
		end
		if (dir) begin
			c = cv;
			b = bv + cv;
			d = dv;
		end else begin
			c = ch;
			b = bh + ch;
			d = dh;
		end
		if (mode_decode)
			grow = it.step_bit;
		else
			grow = ((d < 0 && c > 0) || (d > 0 && c < 0));
		if (grow) begin
			c = c + c / 2;
		end else begin
			c = -c;
			if (magnitude(c) >= 2 * int'(step_floor))
				c = c / 2;
		end
		c = (c < -2048) ? -2048 : ((c > 2047) ? 2047 : c);
		b = (b < 0) ? 0 : ((b > 2047) ? 2047 : b);
		upper_val[col] = value_t'(b);
		upper_stp[col] = step_t'(c);
		left_val = value_t'(b);
		left_stp = step_t'(c);
		cur_dir  = dir;
		w = (width_reg == 0 || width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
		col_pos = col + 1;
		if (col_pos >= w)
			col_pos = 0;
		r.dir   = dir;
		r.grow  = grow;
		r.value = value_t'(b);
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] next_pixel();
		int v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 255;
			2, 3: v = int'($urandom_range(0, 255));
			default: v = int'(last_px) + int'($urandom_range(0, 40)) - 20;
		endcase
		v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
		last_px = v[PIX_W-1:0];
		return last_px;
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic dbit, input logic sbit,
		input logic ls, input logic fs);
		pixel_item_t it;
		int          gap;
		it.pixel       = px;
		it.dir_bit     = dbit;
		it.step_bit    = sbit;
		it.line_start  = ls;
		it.frame_start = fs;
		gap = draw_gap(src_burst);
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid       <= 1'b1;
		pix_if.pixel       <= px;
		pix_if.dir_bit_in  <= dbit;
		pix_if.step_bit_in <= sbit;
		pix_if.line_start  <= ls;
		pix_if.frame_start <= fs;
		do @(posedge clk); while (!pix_if.ready);
		pending_results.push_back(predict_pixel(it));
	endtask

	task automatic settle();
		pix_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		case (idx)
			CFG_DECODE_MODE:     mode_decode = val[0];
			CFG_LINE_WIDTH:      width_reg   = val[LINE_W-1:0];
			CFG_CHANGE_BIAS:     bias_reg    = val[BIAS_W-1:0];
			CFG_STEP_MIN:        step_floor  = val[SMIN_W-1:0];
			CFG_START_VALUE:     init_value  = val[SVAL_W-1:0];
			CFG_START_STEP:      init_step   = val[SSTEP_W-1:0];
			CFG_START_DIRECTION: init_dir    = val[0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_encode_extremes();
		send_pixel(8'd255, 1'b1, 1'b1, 1'b0, 1'b1);
		send_pixel(8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
		send_pixel(8'd0, 1'b1, 1'b0, 1'b0, 1'b0);
		send_pixel(8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
		send_pixel(8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
		settle();
		write_reg(CFG_CHANGE_BIAS, 255);
		write_reg(CFG_START_DIRECTION, 1);
		send_pixel(8'd0, 1'b1, 1'b1, 1'b0, 1'b1);
		send_pixel(8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
	endtask

	task automatic test_decode_saturation();
		settle();
		write_reg(CFG_DECODE_MODE, 1);
		write_reg(CFG_START_VALUE, 255);
		write_reg(CFG_START_STEP, 255);
		write_reg(CFG_START_DIRECTION, 0);
		send_pixel(8'd0, 1'b0, 1'b1, 1'b0, 1'b1);
		repeat (3) send_pixel(8'd255, 1'b0, 1'b1, 1'b0, 1'b0);
		send_pixel(8'd0, 1'b1, 1'b1, 1'b0, 1'b0);
		send_pixel(8'd0, 1'b1, 1'b0, 1'b0, 1'b0);
		settle();
		// start step of -255 against a zero start value
		write_reg(CFG_START_VALUE, 0);
		write_reg(CFG_START_STEP, (-255) & 'h1FF);
		send_pixel(8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
		send_pixel(8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
	endtask

	task automatic test_line_overrun();
		settle();
		write_reg(CFG_DECODE_MODE, 0);
		write_reg(CFG_LINE_WIDTH, 3);
		send_pixel(8'd40, 1'b0, 1'b0, 1'b0, 1'b1);
		send_pixel(8'd90, 1'b0, 1'b0, 1'b0, 1'b0);
		send_pixel(8'd10, 1'b0, 1'b0, 1'b0, 1'b0);
		send_pixel(8'd200, 1'b0, 1'b0, 1'b0, 1'b0);
		settle();
		write_reg(CFG_LINE_WIDTH, 0);
		send_pixel(8'd77, 1'b0, 1'b0, 1'b1, 1'b0);
		settle();
		write_reg(CFG_LINE_WIDTH, 1023);
		send_pixel(8'd128, 1'b1, 1'b1, 1'b0, 1'b0);
	endtask

	task automatic test_step_min_zero();
		settle();
		write_reg(CFG_DECODE_MODE, 1);
		write_reg(CFG_STEP_MIN, 0);
		write_reg(CFG_START_STEP, 1);
		send_pixel(8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
		send_pixel(8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
	endtask

	task automatic test_register_change();
		settle();
		write_reg(CFG_DECODE_MODE, 0);
		write_reg(CFG_START_VALUE, 0);
		write_reg(CFG_START_STEP, 0);
		// no restart: left references still hold the old values
		send_pixel(8'd10, 1'b0, 1'b0, 1'b0, 1'b0);
		send_pixel(8'd10, 1'b0, 1'b0, 1'b1, 1'b0);
	endtask

	task automatic test_random_phases();
		int unsigned w, eff, pos;
		int          s;
		logic        ls, fs;
		for (int ph = 0; ph < 9; ph++) begin
			settle();
			case ($urandom_range(0, 9))
				0: w = 1;
				1: w = 2;
				8: w = $urandom_range(17, 64);
				9: w = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(512, 1023);
				default: w = $urandom_range(3, 16);
			endcase
			eff = (w == 0 || w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
			write_reg(CFG_DECODE_MODE, $urandom_range(0, 1));
			write_reg(CFG_LINE_WIDTH, w);
			case ($urandom_range(0, 5))
				0: write_reg(CFG_CHANGE_BIAS, 0);
				1: write_reg(CFG_CHANGE_BIAS, 255);
				2: write_reg(CFG_CHANGE_BIAS, $urandom_range(0, 255));
				default: write_reg(CFG_CHANGE_BIAS, $urandom_range(0, 15));
			endcase
			case ($urandom_range(0, 5))
				0: write_reg(CFG_STEP_MIN, 0);
				1: write_reg(CFG_STEP_MIN, 255);
				2: write_reg(CFG_STEP_MIN, $urandom_range(0, 255));
				default: write_reg(CFG_STEP_MIN, $urandom_range(1, 8));
			endcase
			write_reg(CFG_START_VALUE, $urandom_range(0, 255));
			s = int'($urandom_range(0, 510)) - 255;
			write_reg(CFG_START_STEP, s & 'h1FF);
			write_reg(CFG_START_DIRECTION, $urandom_range(0, 1));
			src_burst = ($urandom_range(0, 3) == 0);
			snk_burst = ($urandom_range(0, 3) == 0);
			pos = 0;
			for (int n = 0; n < 125; n++) begin
				fs = 1'b0;
				ls = 1'b0;
				if (n == 0)
					fs = ($urandom_range(0, 3) != 0);
				else if (pos == 0)
					fs = ($urandom_range(0, 7) == 0);
				if (pos == 0)
					ls = ($urandom_range(0, 15) != 0);
				if ($urandom_range(0, 63) == 0)
					ls = 1'b1;
				if ($urandom_range(0, 127) == 0)
					fs = 1'b1;
				if (ls || fs)
					pos = 0;
				send_pixel(next_pixel(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					ls, fs);
				pos = (pos + 1 >= eff) ? 0 : pos + 1;
			end
		end
	endtask

	task automatic test_wide_line();
		settle();
		write_reg(CFG_DECODE_MODE, $urandom_range(0, 1));
		write_reg(CFG_LINE_WIDTH, ($urandom_range(0, 1) == 0) ? 0 : MAX_WIDTH_DEF);
		src_burst = 1'b0;
		snk_burst = 1'b0;
		// runs past the end of a full line so the second line reads the store
		send_pixel(next_pixel(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'b0, 1'b1);
		repeat (529)
			send_pixel(next_pixel(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'b0, 1'b0);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL adaptive_delta_pixel_codec");
			$finish;
		end
	end

	// result transfer check
	always @(posedge clk) begin : check_results
		codec_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: dir %0d grow %0d value %0d",
						res_if.dir_bit_out, res_if.step_bit_out, res_if.recon_value);
			end else begin
				want = pending_results.pop_front();
				if (res_if.dir_bit_out !== want.dir || res_if.step_bit_out !== want.grow
					|| res_if.recon_value !== want.value) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch: dir %0d/%0d grow %0d/%0d value %0d/%0d",
							want.dir, res_if.dir_bit_out, want.grow, res_if.step_bit_out,
							want.value, res_if.recon_value);
				end
			end
		end
	end

	initial begin : drain_results
		int gap;
		res_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(snk_burst);
			if (gap > 0) begin
				res_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!(res_if.valid && res_if.ready));
		end
	end

	initial begin
		cycle_count        = 0;
		fault_count        = 0;
		src_burst          = 1'b0;
		snk_burst          = 1'b0;
		last_px            = 8'd128;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= CFG_DECODE_MODE;
		cfg_data           <= '0;
		pix_if.valid       <= 1'b0;
		pix_if.pixel       <= '0;
		pix_if.dir_bit_in  <= 1'b0;
		pix_if.step_bit_in <= 1'b0;
		pix_if.line_start  <= 1'b0;
		pix_if.frame_start <= 1'b0;
		mode_decode = 1'b0;
		width_reg   = LINE_WIDTH_RST;
		bias_reg    = CHANGE_BIAS_RST;
		step_floor  = STEP_MIN_RST;
		init_value  = START_VALUE_RST;
		init_step   = START_STEP_RST;
		init_dir    = 1'b0;
		restart_frame();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_encode_extremes();
		test_decode_saturation();
		test_line_overrun();
		test_step_min_zero();
		test_register_change();
		test_random_phases();
		test_wide_line();

		settle();
		repeat (8) @(posedge clk);
		if (fault_count == 0 && pending_results.size() == 0)
			$display("PASS adaptive_delta_pixel_codec");
		else
			$display("FAIL adaptive_delta_pixel_codec");
		$finish;
	end

endmodule
